### src/mer_pkg.sv
// Package for the midpoint ellipse rasterizer: field widths, stream packing,
// operation codes and the command and status types between controller and datapath.
// No dependencies.
package mer_pkg;

    localparam int COORD_W = 12;
    localparam int RAD_W   = 11;
    localparam int PIX_W   = COORD_W + 2;
    localparam int SQ_W    = 2 * RAD_W;
    localparam int X_W     = RAD_W + 3;
    localparam int A_W     = X_W + 1;
    localparam int MB_W    = 2 * A_W;
    localparam int PROD_W  = SQ_W + MB_W;
    localparam int TERM_W  = SQ_W + X_W + 2;
    localparam int DEC_W   = PROD_W + 4;

    localparam int S_FIELDS_W = 2 * COORD_W + 2 * RAD_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 2 * PIX_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    localparam int PIX_PER_ITEM = 4;
    localparam int IDX_W        = $clog2(PIX_PER_ITEM);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIX_PER_ITEM - 1);

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_SQX,
        DP_SQY,
        DP_MRY,
        DP_AINIT,
        DP_ASUB,
        DP_RND,
        DP_MAA,
        DP_MPA,
        DP_MBB,
        DP_MPB,
        DP_MRR,
        DP_UPD1,
        DP_UPD2,
        DP_DECX,
        DP_DECY,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op           op;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic xt_lt_yt;
        logic y_zero;
        logic out_free;
    } t_dp_stat;

endpackage

### src/mer_datapath.sv
// Datapath of the midpoint ellipse rasterizer: ellipse state, shared multiplier,
// decision accumulator and the registered output stage of the master stream.
// Depends on mer_pkg.
module mer_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mer_pkg::t_dp_cmd            i_cmd,
    input  logic [mer_pkg::S_TDATA_W-1:0] i_s_data,
    input  logic                        i_m_ready,
    output mer_pkg::t_dp_stat           o_stat,
    output logic                        o_m_valid,
    output logic [mer_pkg::M_TDATA_W-1:0] o_m_data,
    output logic                        o_m_last,
    output logic                        o_m_done
);
    import mer_pkg::*;

    logic [COORD_W-1:0]       r_cx;
    logic [COORD_W-1:0]       r_cy;
    logic [RAD_W-1:0]         r_rx;
    logic [RAD_W-1:0]         r_ry;
    logic [SQ_W-1:0]          r_rx2;
    logic [SQ_W-1:0]          r_ry2;
    logic [X_W-1:0]           r_x;
    logic [RAD_W-1:0]         r_y;
    logic signed [TERM_W-1:0] r_xterm;
    logic signed [TERM_W-1:0] r_yterm;
    logic signed [DEC_W-1:0]  r_d;
    logic signed [DEC_W-1:0]  r_acc;
    logic [PROD_W-1:0]        r_prod;
    logic                     r_use_x;
    logic                     r_use_y;
    logic                     r_m_valid;
    logic [PIX_W-1:0]         r_pix_x;
    logic [PIX_W-1:0]         r_pix_y;
    logic                     r_last;
    logic                     r_done;

    logic [SQ_W-1:0]          mul_a;
    logic [MB_W-1:0]          mul_b;
    logic                     mul_en;
    logic [A_W-1:0]           a_val;
    logic [RAD_W-1:0]         b_val;
    logic signed [TERM_W-1:0] ry2_2;
    logic signed [TERM_W-1:0] rx2_2;
    logic signed [DEC_W-1:0]  rnd_sum;
    logic signed [DEC_W-1:0]  rnd_val;
    logic                     d_neg;
    logic                     d_pos;
    logic [PIX_W-1:0]         pcx;
    logic [PIX_W-1:0]         pcy;
    logic [PIX_W-1:0]         px;
    logic [PIX_W-1:0]         py;
    logic [PIX_W-1:0]         pix_x;
    logic [PIX_W-1:0]         pix_y;

    assign a_val   = {r_x, 1'b1};
    assign b_val   = r_y - RAD_W'(1);
    assign ry2_2   = TERM_W'({r_ry2, 1'b0});
    assign rx2_2   = TERM_W'({r_rx2, 1'b0});
    assign d_neg   = r_d[DEC_W-1];
    assign d_pos   = !d_neg && (r_d != '0);
    assign rnd_sum = r_acc + $signed(DEC_W'(r_acc[DEC_W-1] ? 1 : 2));
    assign rnd_val = rnd_sum >>> 2;

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (i_cmd.op)
            DP_SQX: begin
                mul_a = SQ_W'(r_rx);
                mul_b = MB_W'(r_rx);
            end
            DP_SQY: begin
                mul_a = SQ_W'(r_ry);
                mul_b = MB_W'(r_ry);
            end
            DP_MRY: begin
                mul_a = r_rx2;
                mul_b = MB_W'(r_ry);
            end
            DP_MAA: begin
                mul_a = SQ_W'(a_val);
                mul_b = MB_W'(a_val);
            end
            DP_MPA: begin
                mul_a = r_ry2;
                mul_b = r_prod[MB_W-1:0];
            end
            DP_MBB: begin
                mul_a = SQ_W'(b_val);
                mul_b = MB_W'(b_val);
            end
            DP_MPB: begin
                mul_a = r_rx2;
                mul_b = r_prod[MB_W-1:0];
            end
            DP_MRR: begin
                mul_a = r_rx2;
                mul_b = MB_W'(r_ry2);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        unique case (i_cmd.op)
            DP_NOP: ;
            DP_LOAD: begin
                r_cx    <= i_s_data[COORD_W-1:0];
                r_cy    <= i_s_data[2*COORD_W-1:COORD_W];
                r_rx    <= i_s_data[2*COORD_W+RAD_W-1:2*COORD_W];
                r_ry    <= i_s_data[2*COORD_W+2*RAD_W-1:2*COORD_W+RAD_W];
                r_x     <= '0;
                r_y     <= i_s_data[2*COORD_W+2*RAD_W-1:2*COORD_W+RAD_W];
                r_xterm <= '0;
            end
            DP_SQX: ;
            DP_SQY: begin
                r_rx2 <= r_prod[SQ_W-1:0];
            end
            DP_MRY: begin
                r_ry2 <= r_prod[SQ_W-1:0];
            end
            DP_AINIT: begin
                r_acc   <= $signed(DEC_W'(r_rx2)) + $signed(DEC_W'({r_ry2, 2'b00}));
                r_yterm <= TERM_W'({r_prod, 1'b0});
            end
            DP_ASUB: begin
                r_acc <= r_acc - $signed(DEC_W'({r_prod, 2'b00}));
            end
            DP_RND: begin
                r_d <= rnd_val;
            end
            DP_MAA: ;
            DP_MPA: ;
            DP_MBB: begin
                r_acc <= $signed(DEC_W'(r_prod));
            end
            DP_MPB: ;
            DP_MRR: begin
                r_acc <= r_acc + $signed(DEC_W'({r_prod, 2'b00}));
            end
            DP_UPD1: begin
                r_x     <= r_x + X_W'(1);
                r_xterm <= r_xterm + ry2_2;
                if (!d_neg) begin
                    r_y     <= r_y - RAD_W'(1);
                    r_yterm <= r_yterm - rx2_2;
                end
                r_use_x <= 1'b1;
                r_use_y <= !d_neg;
                r_acc   <= r_d + $signed(DEC_W'(r_ry2));
            end
            DP_UPD2: begin
                r_y     <= r_y - RAD_W'(1);
                r_yterm <= r_yterm - rx2_2;
                if (!d_pos) begin
                    r_x     <= r_x + X_W'(1);
                    r_xterm <= r_xterm + ry2_2;
                end
                r_use_x <= !d_pos;
                r_use_y <= 1'b1;
                r_acc   <= r_d + $signed(DEC_W'(r_rx2));
            end
            DP_DECX: begin
                if (r_use_x) begin
                    r_acc <= r_acc + DEC_W'(r_xterm);
                end
            end
            DP_DECY: begin
                r_d <= r_use_y ? r_acc - DEC_W'(r_yterm) : r_acc;
            end
            DP_EMIT: begin
                r_pix_x <= pix_x;
                r_pix_y <= pix_y;
                r_last  <= (i_cmd.idx == LAST_IDX);
                r_done  <= (i_cmd.idx == LAST_IDX) && (r_y == '0);
            end
        endcase
    end

    assign pcx   = PIX_W'(r_cx);
    assign pcy   = PIX_W'(r_cy);
    assign px    = PIX_W'(r_x);
    assign py    = PIX_W'(r_y);
    assign pix_x = i_cmd.idx[0] ? pcx - px : pcx + px;
    assign pix_y = i_cmd.idx[1] ? pcy - py : pcy + py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.op == DP_EMIT) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign o_stat.xt_lt_yt = (r_xterm < r_yterm);
    assign o_stat.y_zero   = (r_y == '0);
    assign o_stat.out_free = !r_m_valid || i_m_ready;

    assign o_m_valid = r_m_valid;
    assign o_m_data  = {{M_PAD_W{1'b0}}, r_pix_y, r_pix_x};
    assign o_m_last  = r_last;
    assign o_m_done  = r_done;

endmodule

### src/mer_ctrl.sv
// Controller of the midpoint ellipse rasterizer: sequences setup, region steps
// and pixel emission, and issues one datapath command per cycle.
// Depends on mer_pkg.
module mer_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    input  logic              i_op,
    input  mer_pkg::t_dp_stat i_stat,
    output logic              o_s_ready,
    output mer_pkg::t_dp_cmd  o_cmd
);
    import mer_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_MRY,
        S_AINIT,
        S_ASUB,
        S_RND,
        S_MAA,
        S_MPA,
        S_MBB,
        S_MPB,
        S_MRR,
        S_UPD1,
        S_UPD2,
        S_DECX,
        S_DECY,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic             r_busy;
    logic             r_region2;
    logic [IDX_W-1:0] r_idx;
    logic             accept;

    assign o_s_ready = (r_state == S_IDLE);
    assign accept    = i_s_valid && o_s_ready;

    always_comb begin
        o_cmd.op  = DP_NOP;
        o_cmd.idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_op == OP_START) begin
                    o_cmd.op = DP_LOAD;
                end
            end
            S_SQX:   o_cmd.op = DP_SQX;
            S_SQY:   o_cmd.op = DP_SQY;
            S_MRY:   o_cmd.op = DP_MRY;
            S_AINIT: o_cmd.op = DP_AINIT;
            S_ASUB:  o_cmd.op = DP_ASUB;
            S_RND:   o_cmd.op = DP_RND;
            S_MAA:   o_cmd.op = DP_MAA;
            S_MPA:   o_cmd.op = DP_MPA;
            S_MBB:   o_cmd.op = DP_MBB;
            S_MPB:   o_cmd.op = DP_MPB;
            S_MRR:   o_cmd.op = DP_MRR;
            S_UPD1:  o_cmd.op = DP_UPD1;
            S_UPD2:  o_cmd.op = DP_UPD2;
            S_DECX:  o_cmd.op = DP_DECX;
            S_DECY:  o_cmd.op = DP_DECY;
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = DP_EMIT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_busy    <= 1'b0;
            r_region2 <= 1'b0;
            r_idx     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        priority if (i_op == OP_START) begin
                            r_state   <= S_SQX;
                            r_busy    <= 1'b1;
                            r_region2 <= 1'b0;
                        end else if (!r_busy) begin
                            r_state <= S_IDLE;
                        end else if (!r_region2 && i_stat.xt_lt_yt) begin
                            r_state <= S_UPD1;
                        end else if (!r_region2) begin
                            r_state   <= S_MAA;
                            r_region2 <= 1'b1;
                        end else begin
                            r_state <= S_UPD2;
                        end
                    end
                end
                S_SQX:   r_state <= S_SQY;
                S_SQY:   r_state <= S_MRY;
                S_MRY:   r_state <= S_AINIT;
                S_AINIT: r_state <= S_ASUB;
                S_ASUB:  r_state <= S_RND;
                S_RND: begin
                    r_idx   <= '0;
                    r_state <= r_region2 ? S_UPD2 : S_EMIT;
                end
                S_MAA:   r_state <= S_MPA;
                S_MPA:   r_state <= S_MBB;
                S_MBB:   r_state <= S_MPB;
                S_MPB:   r_state <= S_MRR;
                S_MRR:   r_state <= S_ASUB;
                S_UPD1:  r_state <= S_DECX;
                S_UPD2:  r_state <= S_DECX;
                S_DECX:  r_state <= S_DECY;
                S_DECY: begin
                    r_idx   <= '0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_stat.out_free) begin
                        if (r_idx == LAST_IDX) begin
                            r_state <= S_IDLE;
                            if (i_stat.y_zero) begin
                                r_busy <= 1'b0;
                            end
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end
                end
            endcase
        end
    end

endmodule

### src/midpoint_ellipse_rasterizer_core.sv
// Top level of the midpoint ellipse rasterizer: joins the controller and the datapath.
// Depends on mer_pkg, mer_ctrl and mer_datapath.
//
// Usage: each slave-stream transaction is one command. tuser bit 0 selects start
// (0) or step (1); tdata carries center_x, center_y, radius_x, radius_y, used on
// start only. A start loads the ellipse and emits the four mirrored points of
// (0, radius_y); each step runs one midpoint iteration and emits four mirrored
// pixels. A step after the ellipse is finished emits nothing. Every pixel leaves
// as one master-stream transaction: tdata holds pixel_x and pixel_y, tlast marks
// the fourth pixel of a run and tuser bit 0 flags the end of the ellipse.
// A start runs squares, decision setup and rounding before its pixels, a step its
// update and decision states, and the first region-two step also recomputes the
// decision value, since the single shared multiplier forms the squares and the
// region-two decision value one product per cycle. Pixels leave one per cycle
// unless stalled. Commands are taken one at a time; tready rises again once the
// last pixel sits in the output register. A stalled receiver holds the output
// register and the emission sequence. Reset (synchronous, active low) empties
// the output register and leaves no ellipse in progress.
module midpoint_ellipse_rasterizer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tdata: center_x, center_y, radius_x, radius_y, zero padding
    input  logic [mer_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: op
    input  logic [0:0]                    i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // tdata: pixel_x, pixel_y, zero padding
    output logic [mer_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    output logic                          o_m_axis_tlast,
    // tuser: done_res
    output logic [0:0]                    o_m_axis_tuser
);
    import mer_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    mer_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_op      (i_s_axis_tuser[0]),
        .i_stat    (stat),
        .o_s_ready (o_s_axis_tready),
        .o_cmd     (cmd)
    );

    mer_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_s_data  (i_s_axis_tdata),
        .i_m_ready (i_m_axis_tready),
        .o_stat    (stat),
        .o_m_valid (o_m_axis_tvalid),
        .o_m_data  (o_m_axis_tdata),
        .o_m_last  (o_m_axis_tlast),
        .o_m_done  (o_m_axis_tuser[0])
    );

endmodule
